// ===== sv/apu_channel_mixer_filter_defines.svh =====
// Assertion macros used by the channel mixer and filter top module.
// Both macros sample on clk and are disabled while rst is high.
`ifndef APU_CHANNEL_MIXER_FILTER_DEFINES_SVH
`define APU_CHANNEL_MIXER_FILTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ACMF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ACMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/acmf_pkg.sv =====
package acmf_pkg;

  localparam int DEF_SAMPLE_BITS       = 16;
  localparam int DEF_PULSE_TABLE_DEPTH = 31;
  localparam int DEF_MIX_TABLE_DEPTH   = 203;

  // Headroom of the filter state above the sample width.
  localparam int STATE_EXTRA_BITS = 8;
  // Extra bits of the difference operands ahead of the coefficient multiply.
  localparam int OPND_EXTRA_BITS  = 3;

  localparam int COEF_BITS      = 16;
  localparam int PULSE_SUM_BITS = 5;
  localparam int TND_SUM_BITS   = 8;

  // Nonlinear mixer curve: value = NUM*i / (DEN0 + DEN_STEP*i).
  localparam longint unsigned PULSE_NUM  = 9552;
  localparam longint unsigned PULSE_DEN0 = 812800;
  localparam longint unsigned TND_NUM    = 16367;
  localparam longint unsigned TND_DEN0   = 2432900;
  localparam longint unsigned DEN_STEP   = 10000;

  localparam logic [COEF_BITS-1:0] HP90_RESET  = 16'd64706;
  localparam logic [COEF_BITS-1:0] HP440_RESET = 16'd61670;
  localparam logic [COEF_BITS-1:0] LP14K_RESET = 16'd43652;

  localparam int CFG_INDEX_BITS = 2;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  localparam cfg_index_t CFG_HP90  = 2'd0;
  localparam cfg_index_t CFG_HP440 = 2'd1;
  localparam cfg_index_t CFG_LP14K = 2'd2;

  typedef struct packed {
    logic [3:0] pulse1_level;
    logic [3:0] pulse2_level;
    logic [3:0] triangle_level;
    logic [3:0] noise_level;
    logic [6:0] dmc_level;
  } levels_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_LOAD,
    ST_MUL,
    ST_WRITE
  } state_t;

  typedef enum logic [1:0] {
    PASS_HP90,
    PASS_HP440,
    PASS_LP
  } pass_t;

endpackage

// ===== sv/acmf_in_if.sv =====
interface acmf_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] pulse1_level;
  logic [3:0] pulse2_level;
  logic [3:0] triangle_level;
  logic [3:0] noise_level;
  logic [6:0] dmc_level;

  modport source (output valid, output pulse1_level, output pulse2_level,
                  output triangle_level, output noise_level, output dmc_level,
                  input ready);
  modport sink (input valid, input pulse1_level, input pulse2_level,
                input triangle_level, input noise_level, input dmc_level,
                output ready);
endinterface

// ===== sv/acmf_out_if.sv =====
interface acmf_out_if #(
  parameter int SAMPLE_BITS = acmf_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// ===== sv/acmf_cfg_if.sv =====
interface acmf_cfg_if;
  logic                                  valid;
  logic                                  ready;
  acmf_pkg::cfg_index_t                  index;
  logic [acmf_pkg::COEF_BITS-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/acmf_mix.sv =====
module acmf_mix #(
  parameter int SAMPLE_BITS       = acmf_pkg::DEF_SAMPLE_BITS,
  parameter int PULSE_TABLE_DEPTH = acmf_pkg::DEF_PULSE_TABLE_DEPTH,
  parameter int MIX_TABLE_DEPTH   = acmf_pkg::DEF_MIX_TABLE_DEPTH
) (
  input  acmf_pkg::levels_t             lvl,
  output logic signed [SAMPLE_BITS-1:0] mixed
);
  import acmf_pkg::*;

  localparam int FRAC      = SAMPLE_BITS - 1;
  localparam int PIDX_BITS = $clog2(PULSE_TABLE_DEPTH);
  localparam int TIDX_BITS = $clog2(MIX_TABLE_DEPTH);
  localparam int WIDE      = SAMPLE_BITS + 2;

  localparam logic signed [WIDE-1:0] ONE = WIDE'(64'sd1 <<< FRAC);
  localparam logic signed [WIDE-1:0] HI  = WIDE'((64'sd1 <<< FRAC) - 1);
  localparam logic signed [WIDE-1:0] LO  = WIDE'(-(64'sd1 <<< FRAC));

  logic [FRAC-1:0] pulse_tab [PULSE_TABLE_DEPTH];
  logic [FRAC-1:0] tnd_tab   [MIX_TABLE_DEPTH];

  // Round-half-up of the mixer curve, worked out at elaboration.
  for (genvar i = 0; i < PULSE_TABLE_DEPTH; i++) begin : g_pulse
    localparam longint unsigned DEN = PULSE_DEN0 + DEN_STEP * i;
    localparam longint unsigned NUM = 2 * PULSE_NUM * i * (64'd1 << FRAC) + DEN;
    localparam longint unsigned VAL = NUM / (2 * DEN);
    assign pulse_tab[i] = FRAC'(VAL);
  end

  for (genvar i = 0; i < MIX_TABLE_DEPTH; i++) begin : g_tnd
    localparam longint unsigned DEN = TND_DEN0 + DEN_STEP * i;
    localparam longint unsigned NUM = 2 * TND_NUM * i * (64'd1 << FRAC) + DEN;
    localparam longint unsigned VAL = NUM / (2 * DEN);
    assign tnd_tab[i] = FRAC'(VAL);
  end

  logic [PULSE_SUM_BITS-1:0] pulse_sum;
  logic [TND_SUM_BITS-1:0]   tnd_sum;
  logic [PIDX_BITS-1:0]      pulse_idx;
  logic [TIDX_BITS-1:0]      tnd_idx;
  logic [FRAC:0]             rom_sum;
  logic signed [WIDE-1:0]    centered;

  always_comb begin
    pulse_sum = PULSE_SUM_BITS'(lvl.pulse1_level) + PULSE_SUM_BITS'(lvl.pulse2_level);
    tnd_sum   = TND_SUM_BITS'({lvl.triangle_level, 1'b0}) + TND_SUM_BITS'(lvl.triangle_level)
              + TND_SUM_BITS'({lvl.noise_level, 1'b0}) + TND_SUM_BITS'(lvl.dmc_level);

    // Clamp to the last entry when the table is shorter than the index range.
    if (32'(pulse_sum) > 32'(PULSE_TABLE_DEPTH - 1)) begin
      pulse_idx = PIDX_BITS'(PULSE_TABLE_DEPTH - 1);
    end else begin
      pulse_idx = PIDX_BITS'(pulse_sum);
    end
    if (32'(tnd_sum) > 32'(MIX_TABLE_DEPTH - 1)) begin
      tnd_idx = TIDX_BITS'(MIX_TABLE_DEPTH - 1);
    end else begin
      tnd_idx = TIDX_BITS'(tnd_sum);
    end

    rom_sum  = (FRAC+1)'(pulse_tab[pulse_idx]) + (FRAC+1)'(tnd_tab[tnd_idx]);
    centered = $signed({1'b0, rom_sum, 1'b0}) - ONE;

    if (centered > HI) begin
      mixed = SAMPLE_BITS'(HI);
    end else if (centered < LO) begin
      mixed = SAMPLE_BITS'(LO);
    end else begin
      mixed = SAMPLE_BITS'(centered);
    end
  end

endmodule

// ===== sv/acmf_mul.sv =====
module acmf_mul #(
  parameter int OPND_BITS = acmf_pkg::DEF_SAMPLE_BITS + acmf_pkg::STATE_EXTRA_BITS
                          + acmf_pkg::OPND_EXTRA_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [acmf_pkg::COEF_BITS-1:0] coef,
  input  logic signed [OPND_BITS-1:0]    operand,
  output logic                           done,
  output logic signed [OPND_BITS-1:0]    product
);
  import acmf_pkg::*;

  localparam int ACC_BITS = OPND_BITS + COEF_BITS;
  localparam int CNT_BITS = $clog2(COEF_BITS);
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(COEF_BITS - 1);
  localparam logic signed [ACC_BITS-1:0] ROUND = ACC_BITS'(64'sd1 <<< (COEF_BITS - 1));

  logic                        busy;
  logic [CNT_BITS-1:0]         cnt;
  logic [COEF_BITS-1:0]        coef_sr;
  logic signed [OPND_BITS-1:0] opnd;
  logic signed [ACC_BITS-1:0]  acc;
  logic signed [ACC_BITS-1:0]  addend;
  logic signed [ACC_BITS-1:0]  rounded;

  // One coefficient bit per cycle, most significant first.
  always_comb begin
    addend  = coef_sr[COEF_BITS-1] ? ACC_BITS'(opnd) : '0;
    rounded = acc + ROUND;
    product = rounded[ACC_BITS-1:COEF_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc     <= '0;
      coef_sr <= coef;
      opnd    <= operand;
    end else if (busy) begin
      acc     <= (acc <<< 1) + addend;
      coef_sr <= coef_sr << 1;
    end
  end

endmodule

// ===== sv/apu_channel_mixer_filter.sv =====
// A new input beat is taken only in the idle state, once the previous sample
// has gone to the output register; the three filter multiplies run in turn on
// the shared shift-add multiplier, one coefficient bit a cycle.
// The output register holds a finished sample while the next one is computed.
// Reset: synchronous, clears filter state and restores default coefficients.
`include "apu_channel_mixer_filter_defines.svh"

module apu_channel_mixer_filter #(
  parameter int SAMPLE_BITS       = acmf_pkg::DEF_SAMPLE_BITS,
  parameter int PULSE_TABLE_DEPTH = acmf_pkg::DEF_PULSE_TABLE_DEPTH,
  parameter int MIX_TABLE_DEPTH   = acmf_pkg::DEF_MIX_TABLE_DEPTH
) (
  input logic       clk,
  input logic       rst,
  acmf_in_if.sink   in_ch,
  acmf_out_if.source out_ch,
  acmf_cfg_if.sink  cfg
);
  import acmf_pkg::*;

  localparam int STATE_BITS = SAMPLE_BITS + STATE_EXTRA_BITS;
  localparam int W          = STATE_BITS + OPND_EXTRA_BITS;

  localparam logic signed [W-1:0] ST_HI = W'((64'sd1 <<< (STATE_BITS - 1)) - 1);
  localparam logic signed [W-1:0] ST_LO = W'(-(64'sd1 <<< (STATE_BITS - 1)));
  localparam logic signed [STATE_BITS-1:0] OUT_HI =
    STATE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [STATE_BITS-1:0] OUT_LO =
    STATE_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  state_t state, state_next;
  pass_t  pass;

  logic [COEF_BITS-1:0] hp90_coef;
  logic [COEF_BITS-1:0] hp440_coef;
  logic [COEF_BITS-1:0] lp14k_coef;

  levels_t                        lvl;
  logic signed [SAMPLE_BITS-1:0]  mix_value;
  logic signed [SAMPLE_BITS-1:0]  mixed;
  logic signed [SAMPLE_BITS-1:0]  last_mixed;
  logic signed [STATE_BITS-1:0]   highpass1_out;
  logic signed [STATE_BITS-1:0]   highpass1_old;
  logic signed [STATE_BITS-1:0]   highpass2_out;
  logic signed [STATE_BITS-1:0]   lowpass_out;

  logic                           out_valid;
  logic signed [SAMPLE_BITS-1:0]  out_sample;
  logic signed [SAMPLE_BITS-1:0]  out_sat;

  logic                  mul_start;
  logic                  mul_done;
  logic [COEF_BITS-1:0]  mul_coef;
  logic signed [W-1:0]   mul_opnd;
  logic signed [W-1:0]   mul_prod;
  logic signed [W-1:0]   lp_sum;
  logic signed [W-1:0]   sat_in;
  logic signed [STATE_BITS-1:0] sat_out;

  logic in_beat;
  logic out_free;

  acmf_mix #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .PULSE_TABLE_DEPTH(PULSE_TABLE_DEPTH),
    .MIX_TABLE_DEPTH  (MIX_TABLE_DEPTH)
  ) u_mix (
    .lvl  (lvl),
    .mixed(mix_value)
  );

  acmf_mul #(
    .OPND_BITS(W)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .coef   (mul_coef),
    .operand(mul_opnd),
    .done   (mul_done),
    .product(mul_prod)
  );

  assign cfg.ready      = 1'b1;
  assign out_ch.valid   = out_valid;
  assign out_ch.sample_out = out_sample;
  assign in_beat        = in_ch.valid && in_ch.ready;
  assign out_free       = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hp90_coef  <= HP90_RESET;
      hp440_coef <= HP440_RESET;
      lp14k_coef <= LP14K_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_HP90:  hp90_coef  <= cfg.data;
        CFG_HP440: hp440_coef <= cfg.data;
        CFG_LP14K: lp14k_coef <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    mul_start   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: state_next = ST_LOAD;
      ST_LOAD: begin
        mul_start  = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          state_next = (pass == PASS_LP) ? ST_WRITE : ST_LOAD;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Operand and coefficient for the filter stage in progress.
  always_comb begin
    case (pass)
      PASS_HP90: begin
        mul_coef = hp90_coef;
        mul_opnd = W'(highpass1_out) + W'(mixed) - W'(last_mixed);
      end
      PASS_HP440: begin
        mul_coef = hp440_coef;
        mul_opnd = W'(highpass2_out) + W'(highpass1_out) - W'(highpass1_old);
      end
      PASS_LP: begin
        mul_coef = lp14k_coef;
        mul_opnd = W'(highpass2_out) - W'(lowpass_out);
      end
      default: begin
        mul_coef = '0;
        mul_opnd = '0;
      end
    endcase
  end

  always_comb begin
    lp_sum = W'(lowpass_out) + mul_prod;
    sat_in = (pass == PASS_LP) ? lp_sum : mul_prod;
    if (sat_in > ST_HI) begin
      sat_out = STATE_BITS'(ST_HI);
    end else if (sat_in < ST_LO) begin
      sat_out = STATE_BITS'(ST_LO);
    end else begin
      sat_out = STATE_BITS'(sat_in);
    end

    if (lowpass_out > OUT_HI) begin
      out_sat = SAMPLE_BITS'(OUT_HI);
    end else if (lowpass_out < OUT_LO) begin
      out_sat = SAMPLE_BITS'(OUT_LO);
    end else begin
      out_sat = SAMPLE_BITS'(lowpass_out);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass          <= PASS_HP90;
      last_mixed    <= '0;
      highpass1_out <= '0;
      highpass2_out <= '0;
      lowpass_out   <= '0;
    end else begin
      if (state == ST_LOOKUP) begin
        pass <= PASS_HP90;
      end
      if (state == ST_MUL && mul_done) begin
        case (pass)
          PASS_HP90: begin
            highpass1_out <= sat_out;
            last_mixed    <= mixed;
            pass          <= PASS_HP440;
          end
          PASS_HP440: begin
            highpass2_out <= sat_out;
            pass          <= PASS_LP;
          end
          PASS_LP: lowpass_out <= sat_out;
          default: pass <= PASS_HP90;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      lvl <= '{pulse1_level:   in_ch.pulse1_level,
               pulse2_level:   in_ch.pulse2_level,
               triangle_level: in_ch.triangle_level,
               noise_level:    in_ch.noise_level,
               dmc_level:      in_ch.dmc_level};
    end
    if (state == ST_LOOKUP) begin
      mixed <= mix_value;
    end
    // Keep the pre-update first high-pass output for the second stage.
    if (state == ST_MUL && mul_done && pass == PASS_HP90) begin
      highpass1_old <= highpass1_out;
    end
    if (state == ST_WRITE && out_free) begin
      out_sample <= out_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_WRITE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  `ACMF_ASSERT_SAME(a_done_in_mul, mul_done, state == ST_MUL, "multiply done outside wait")
  `ACMF_ASSERT_NEXT(a_hold_write, state == ST_WRITE && out_valid && !out_ch.ready, state == ST_WRITE && out_valid, "pending sample overwritten")
  `ACMF_ASSERT_NEXT(a_drain, out_valid && out_ch.ready && state != ST_WRITE, !out_valid, "output beat repeated")
  `ACMF_ASSERT_NEXT(a_last_pass, state == ST_MUL && mul_done && pass == PASS_LP, state == ST_WRITE, "low-pass result not written")

endmodule
